// ===== rtl/infix_to_postfix_converter_assert.svh =====
// Assertion macros used by the infix-to-postfix converter top level.
`ifndef INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH

// Same-cycle implication, checked on the rising clock outside reset.
`define I2P_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock outside reset.
`define I2P_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/i2p_pkg.sv =====
// Shared types, constants and character helpers of the infix-to-postfix converter.
package i2p_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int MAX_RESULTS     = 40;
  localparam int QUEUE_DEPTH     = 4;
  localparam int NUM_WORDS       = 11;
  localparam int WBUF            = 4;
  localparam int LA_DEPTH        = 3;
  localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef logic [7:0] ch_t;

  localparam ch_t CH_LPAREN = 8'h28;
  localparam ch_t CH_RPAREN = 8'h29;
  localparam ch_t CH_CARET  = 8'h5E;
  localparam ch_t CH_SPACE  = 8'h20;

  typedef enum logic [2:0] {
    CLS_OPERAND,
    CLS_BINOP,
    CLS_WORD,
    CLS_LPAREN,
    CLS_RPAREN,
    CLS_SEP
  } cls_t;

  typedef struct packed {
    ch_t  ch;
    cls_t cls;
  } tok_t;

  localparam int TOK_W = $bits(tok_t);

  typedef tok_t [WBUF-1:0]     wbuf_t;
  typedef tok_t [LA_DEPTH-1:0] labuf_t;

  // item handed from the front part to the back part
  typedef struct packed {
    tok_t tok;
    logic fin;
  } item_t;

  // back part status seen by the top level
  typedef struct packed {
    logic idle;
    logic held_v;
  } bstat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT,
    S_OPPOP,
    S_CLOSE,
    S_FLUSH,
    S_FIN
  } bstate_t;

  // word table: first character in the lowest byte
  localparam logic [31:0] WORD_TXT [NUM_WORDS] = '{
    {8'h00, "n", "i", "s"},
    {"t",   "r", "q", "s"},
    {8'h00, "s", "o", "c"},
    {8'h00, "n", "a", "t"},
    {8'h00, "g", "o", "l"},
    {8'h00, 8'h00, "n", "l"},
    {8'h00, 8'h00, "/", "."},
    {8'h00, 8'h00, "*", "."},
    {8'h00, 8'h00, "+", "."},
    {8'h00, 8'h00, "-", "."},
    {8'h00, 8'h00, "^", "."}
  };
  localparam logic [2:0] WORD_LEN [NUM_WORDS] = '{
    3'd3, 3'd4, 3'd3, 3'd3, 3'd3, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2
  };
  localparam ch_t WORD_CODE [NUM_WORDS] = '{
    "s", "q", "c", "t", "l", "n", "d", "m", "a", "u", "p"
  };
  // dotted words end in a non-operand and are followed by a separator
  localparam logic WORD_SEP [NUM_WORDS] = '{
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1
  };

  function automatic logic is_binop(ch_t c);
    return c == "+" || c == "-" || c == "*" || c == "/" || c == "^" ||
           c == "a" || c == "p" || c == "u" || c == "m" || c == "d";
  endfunction

  function automatic logic is_operand(ch_t c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
           (c >= "A" && c <= "Z") || c == ".";
  endfunction

  function automatic cls_t classify(ch_t c);
    cls_t r;
    if (c == "s" || c == "c" || c == "t" || c == "l" || c == ".") r = CLS_WORD;
    else if (is_binop(c))   r = CLS_BINOP;
    else if (is_operand(c)) r = CLS_OPERAND;
    else if (c == CH_LPAREN) r = CLS_LPAREN;
    else if (c == CH_RPAREN) r = CLS_RPAREN;
    else r = CLS_SEP;
    return r;
  endfunction

  function automatic logic [2:0] weight(ch_t op);
    logic [2:0] w;
    case (op)
      "+", "-":                               w = 3'd1;
      "a", "u":                               w = 3'd2;
      "*", "/", "m", "d":                     w = 3'd3;
      "^", "p", "s", "q", "c", "t", "l", "n": w = 3'd4;
      default:                                w = 3'd0;
    endcase
    return w;
  endfunction

  // stacked operator leaves ahead of the incoming one
  function automatic logic pops_before(ch_t top, ch_t cur);
    logic [2:0] wt;
    logic [2:0] wc;
    wt = weight(top);
    wc = weight(cur);
    if (wt == wc) return top != CH_CARET;
    return wt > wc;
  endfunction

endpackage

// ===== rtl/infix_to_postfix_converter.sv =====
// Infix-to-postfix converter: an input item is one expression character, tlast on
// the final character of an expression; result items are postfix characters with
// single spaces between tokens, operator words folded to one-letter codes. A
// front part takes items into a four-entry queue, so input keeps flowing while the
// back part works. The back part loads an item, examines its characters until it
// finds the work buffer empty, pushes each operator onto the stack and closes the
// item; each result character, and a space ahead of it where one is due, passes
// through the held result slot and then the output register. A closing parenthesis
// or the end of an expression pops operators from the stack as results. A stalled
// result receiver holds the back part in place unless results are being dropped.
`include "infix_to_postfix_converter_assert.svh"

module infix_to_postfix_converter
  import i2p_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_char
  input  logic       in_tlast,   // in_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tlast,  // run_last
  output logic [1:0] out_tuser   // [0] expr_done, [1] overflow
);

  logic   q_valid, q_ready;
  item_t  q_item;
  bstat_t bstat;

  // front: accept and classify
  i2p_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_ch    (in_tdata),
    .in_fin   (in_tlast),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  // back: stack sequencer and result register
  i2p_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_ch        (out_tdata),
    .out_run_last  (out_tlast),
    .out_expr_done (out_tuser[0]),
    .out_overflow  (out_tuser[1]),
    .stat          (bstat)
  );

  // checks
  `I2P_ASSERT_IMP(a_done_is_last, out_tvalid && out_tuser[0], out_tlast, "expr_done without run_last")
  `I2P_ASSERT_IMP(a_idle_no_held, bstat.idle, !bstat.held_v, "result held while idle")

endmodule

// ===== rtl/i2p_front.sv =====
// Front part: accepts input items, classifies each character and queues it.
module i2p_front
  import i2p_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  ch_t   in_ch,
  input  logic  in_fin,
  output logic  q_valid,
  input  logic  q_ready,
  output item_t q_item
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           push, pop;
  item_t          new_item;

  assign in_ready = cnt_r != CW'(QUEUE_DEPTH);
  assign q_valid  = cnt_r != '0;
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // classify on the way in
  always_comb begin
    new_item.tok.ch  = in_ch;
    new_item.tok.cls = classify(in_ch);
    new_item.fin     = in_fin;
  end

  // queue pointers
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

// ===== rtl/i2p_back.sv =====
// Back part: word folding, operator stack sequencer and result output register.
module i2p_back
  import i2p_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   q_valid,
  output logic   q_ready,
  input  item_t  q_item,
  output logic   out_valid,
  input  logic   out_ready,
  output ch_t    out_ch,
  output logic   out_run_last,
  output logic   out_expr_done,
  output logic   out_overflow,
  output bstat_t stat
);

  localparam int SCW = $clog2(STACK_DEPTH + 1);
  localparam int SIW = $clog2(STACK_DEPTH);

  bstate_t             state_r, state_nxt;
  wbuf_t               w_r, w_nxt, w_sh;
  logic [2:0]          len_r, len_nxt;
  logic                fin_r, fin_nxt;
  labuf_t              la_r, la_nxt;
  logic [1:0]          la_cnt_r, la_cnt_nxt;
  ch_t                 stack_r [STACK_DEPTH];
  logic [SCW-1:0]      cnt_r, cnt_nxt;
  logic                spc_r, spc_nxt;
  logic                ne_r, ne_nxt;
  logic                ovf_r, ovf_nxt;
  logic                phase_r, phase_nxt;
  ch_t                 op_r, op_nxt;
  logic [2:0]          adv_r, adv_nxt;
  logic                sep_r, sep_nxt;
  logic [RES_CNT_W-1:0] res_cnt_r, res_cnt_nxt;
  ch_t                 held_ch_r, held_ch_nxt;
  logic                held_ovf_r, held_ovf_nxt;
  logic                held_v_r, held_v_nxt;
  logic                ov_r, ov_nxt;
  ch_t                 oc_r, oc_nxt;
  logic                olast_r, olast_nxt;
  logic                odone_r, odone_nxt;
  logic                oovf_r, oovf_nxt;

  logic [2:0]          shift_by;
  logic                push_en;
  ch_t                 push_ch;
  ch_t                 top;
  logic                top_open;
  logic                out_free, slot_ok, drop, go;
  logic                put_req;
  ch_t                 put_ch;
  logic                full_v [NUM_WORDS];
  logic                pref_v [NUM_WORDS];
  logic                full_hit, pref_hit;
  ch_t                 full_code;
  logic [2:0]          full_len;
  logic                full_sep;
  tok_t                x;

  assign top      = stack_r[SIW'(cnt_r - 1'b1)];
  assign top_open = top == CH_LPAREN;
  assign x        = w_r[0];
  assign out_free = !ov_r || out_ready;
  assign slot_ok  = !held_v_r || out_free;
  assign drop     = res_cnt_r >= RES_CNT_W'(MAX_RESULTS);
  assign go       = drop || slot_ok;
  assign q_ready  = state_r == S_IDLE;
  assign w_sh     = wbuf_t'(w_r >> (shift_by * TOK_W));

  assign out_valid     = ov_r;
  assign out_ch        = oc_r;
  assign out_run_last  = olast_r;
  assign out_expr_done = odone_r;
  assign out_overflow  = oovf_r;
  assign stat.idle     = state_r == S_IDLE;
  assign stat.held_v   = held_v_r;

  // word table match against the work buffer
  always_comb begin
    for (int i = 0; i < NUM_WORDS; i++) begin
      full_v[i] = len_r >= WORD_LEN[i];
      pref_v[i] = len_r < WORD_LEN[i];
      for (int k = 0; k < WBUF; k++) begin
        if (3'(k) < WORD_LEN[i] && w_r[k].ch != WORD_TXT[i][k*8 +: 8]) full_v[i] = 1'b0;
        if (3'(k) < len_r && w_r[k].ch != WORD_TXT[i][k*8 +: 8]) pref_v[i] = 1'b0;
      end
    end
    full_hit  = 1'b0;
    pref_hit  = 1'b0;
    full_code = '0;
    full_len  = 3'd1;
    full_sep  = 1'b0;
    for (int i = 0; i < NUM_WORDS; i++) begin
      if (full_v[i]) begin
        full_hit  = 1'b1;
        full_code = WORD_CODE[i];
        full_len  = WORD_LEN[i];
        full_sep  = WORD_SEP[i];
      end
      if (pref_v[i]) pref_hit = 1'b1;
    end
  end

  // sequencer: next state and datapath updates
  always_comb begin
    state_nxt   = state_r;
    w_nxt       = w_r;
    len_nxt     = len_r;
    fin_nxt     = fin_r;
    la_nxt      = la_r;
    la_cnt_nxt  = la_cnt_r;
    cnt_nxt     = cnt_r;
    spc_nxt     = spc_r;
    ne_nxt      = ne_r;
    ovf_nxt     = ovf_r;
    phase_nxt   = phase_r;
    op_nxt      = op_r;
    adv_nxt     = adv_r;
    sep_nxt     = sep_r;
    shift_by    = 3'd1;
    push_en     = 1'b0;
    push_ch     = op_r;
    put_req     = 1'b0;
    put_ch      = x.ch;
    res_cnt_nxt = res_cnt_r;
    held_ch_nxt = held_ch_r;
    held_ovf_nxt = held_ovf_r;
    held_v_nxt  = held_v_r;
    ov_nxt      = out_free ? 1'b0 : ov_r;
    oc_nxt      = oc_r;
    olast_nxt   = olast_r;
    odone_nxt   = odone_r;
    oovf_nxt    = oovf_r;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          for (int k = 0; k < WBUF; k++) begin
            if (k < LA_DEPTH && 2'(k) < la_cnt_r) w_nxt[k] = la_r[k];
            else w_nxt[k] = q_item.tok;
          end
          len_nxt    = {1'b0, la_cnt_r} + 3'd1;
          fin_nxt    = q_item.fin;
          la_cnt_nxt = '0;
          phase_nxt  = 1'b0;
          state_nxt  = S_SCAN;
        end
      end

      S_SCAN: begin
        if (len_r == '0) begin
          state_nxt = fin_r ? S_FLUSH : S_FIN;
        end else begin
          case (x.cls)
            CLS_WORD: begin
              if (full_hit) begin
                op_nxt    = full_code;
                adv_nxt   = full_len;
                sep_nxt   = full_sep;
                state_nxt = S_OPPOP;
              end else if (pref_hit && !fin_r && len_r <= 3'd3) begin
                // hold the prefix until more characters arrive
                la_nxt     = w_r[LA_DEPTH-1:0];
                la_cnt_nxt = len_r[1:0];
                state_nxt  = S_FIN;
              end else begin
                state_nxt = S_EMIT;
              end
            end
            CLS_BINOP: begin
              op_nxt    = x.ch;
              adv_nxt   = 3'd1;
              sep_nxt   = 1'b1;
              state_nxt = S_OPPOP;
            end
            CLS_OPERAND: state_nxt = S_EMIT;
            CLS_LPAREN: begin
              push_en = 1'b1;
              push_ch = CH_LPAREN;
              spc_nxt = spc_r | !ne_r;
              w_nxt   = w_sh;
              len_nxt = len_r - 3'd1;
            end
            CLS_RPAREN: state_nxt = S_CLOSE;
            default: begin
              spc_nxt = spc_r | !ne_r;
              w_nxt   = w_sh;
              len_nxt = len_r - 3'd1;
            end
          endcase
        end
      end

      // operand or failed word prefix: emit the leading character
      S_EMIT: begin
        put_req = 1'b1;
        if (!phase_r && spc_r) begin
          put_ch = CH_SPACE;
          if (go) begin
            phase_nxt = 1'b1;
            spc_nxt   = 1'b0;
          end
        end else begin
          put_ch = x.ch;
          if (go) begin
            phase_nxt = 1'b0;
            spc_nxt   = 1'b0;
            ne_nxt    = 1'b0;
            w_nxt     = w_sh;
            len_nxt   = len_r - 3'd1;
            state_nxt = S_SCAN;
          end
        end
      end

      // pop operators that leave ahead of the incoming one, then push it
      S_OPPOP: begin
        if (cnt_r != '0 && !top_open && pops_before(top, op_r)) begin
          put_req = 1'b1;
          if (!phase_r && !ne_r) begin
            put_ch = CH_SPACE;
            if (go) begin
              phase_nxt = 1'b1;
              spc_nxt   = 1'b0;
            end
          end else begin
            put_ch = top;
            if (go) begin
              phase_nxt = 1'b0;
              spc_nxt   = 1'b0;
              ne_nxt    = 1'b0;
              cnt_nxt   = cnt_r - 1'b1;
            end
          end
        end else begin
          push_en   = 1'b1;
          push_ch   = op_r;
          if (sep_r) spc_nxt = spc_r | !ne_r;
          shift_by  = adv_r;
          w_nxt     = w_sh;
          len_nxt   = len_r - adv_r;
          state_nxt = S_SCAN;
        end
      end

      // closing parenthesis: pop down to the opening one
      S_CLOSE: begin
        if (cnt_r != '0 && !top_open) begin
          put_req = 1'b1;
          if (!phase_r && !ne_r) begin
            put_ch = CH_SPACE;
            if (go) begin
              phase_nxt = 1'b1;
              spc_nxt   = 1'b0;
            end
          end else begin
            put_ch = top;
            if (go) begin
              phase_nxt = 1'b0;
              spc_nxt   = 1'b1;
              ne_nxt    = 1'b0;
              cnt_nxt   = cnt_r - 1'b1;
            end
          end
        end else begin
          if (cnt_r != '0) cnt_nxt = cnt_r - 1'b1;
          spc_nxt   = spc_r | !ne_r;
          w_nxt     = w_sh;
          len_nxt   = len_r - 3'd1;
          state_nxt = S_SCAN;
        end
      end

      // end of expression: drain the stack, then return to reset values
      S_FLUSH: begin
        if (cnt_r != '0) begin
          put_req = 1'b1;
          if (!phase_r && !ne_r) begin
            put_ch = CH_SPACE;
            if (go) begin
              phase_nxt = 1'b1;
              spc_nxt   = 1'b0;
            end
          end else begin
            put_ch = top;
            if (go) begin
              phase_nxt = 1'b0;
              spc_nxt   = 1'b0;
              ne_nxt    = 1'b0;
              cnt_nxt   = cnt_r - 1'b1;
            end
          end
        end else begin
          la_cnt_nxt = '0;
          spc_nxt    = 1'b0;
          ne_nxt     = 1'b1;
          ovf_nxt    = 1'b0;
          state_nxt  = S_FIN;
        end
      end

      // release the held result as the last one of this item
      S_FIN: begin
        if (!held_v_r) begin
          res_cnt_nxt = '0;
          state_nxt   = S_IDLE;
        end else if (out_free) begin
          ov_nxt      = 1'b1;
          oc_nxt      = held_ch_r;
          oovf_nxt    = held_ovf_r;
          olast_nxt   = 1'b1;
          odone_nxt   = fin_r;
          held_v_nxt  = 1'b0;
          res_cnt_nxt = '0;
          state_nxt   = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // push onto the operator stack, flag a full stack
    if (push_en) begin
      if (cnt_r < SCW'(STACK_DEPTH)) cnt_nxt = cnt_r + 1'b1;
      else ovf_nxt = 1'b1;
    end

    // new result goes to the held slot, the previous one moves out
    if (put_req && go && !drop) begin
      if (held_v_r) begin
        ov_nxt    = 1'b1;
        oc_nxt    = held_ch_r;
        oovf_nxt  = held_ovf_r;
        olast_nxt = 1'b0;
        odone_nxt = 1'b0;
      end
      held_ch_nxt  = put_ch;
      held_ovf_nxt = ovf_r;
      held_v_nxt   = 1'b1;
      res_cnt_nxt  = res_cnt_r + 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      la_cnt_r  <= '0;
      cnt_r     <= '0;
      spc_r     <= 1'b0;
      ne_r      <= 1'b1;
      ovf_r     <= 1'b0;
      phase_r   <= 1'b0;
      res_cnt_r <= '0;
      held_v_r  <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      la_cnt_r  <= la_cnt_nxt;
      cnt_r     <= cnt_nxt;
      spc_r     <= spc_nxt;
      ne_r      <= ne_nxt;
      ovf_r     <= ovf_nxt;
      phase_r   <= phase_nxt;
      res_cnt_r <= res_cnt_nxt;
      held_v_r  <= held_v_nxt;
      ov_r      <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    w_r        <= w_nxt;
    len_r      <= len_nxt;
    fin_r      <= fin_nxt;
    la_r       <= la_nxt;
    op_r       <= op_nxt;
    adv_r      <= adv_nxt;
    sep_r      <= sep_nxt;
    held_ch_r  <= held_ch_nxt;
    held_ovf_r <= held_ovf_nxt;
    oc_r       <= oc_nxt;
    olast_r    <= olast_nxt;
    odone_r    <= odone_nxt;
    oovf_r     <= oovf_nxt;
  end

  // operator stack storage
  always_ff @(posedge clk) begin
    if (push_en && cnt_r < SCW'(STACK_DEPTH)) begin
      stack_r[SIW'(cnt_r)] <= push_ch;
    end
  end

endmodule

// ===== test/tb_infix_to_postfix_converter.sv =====
// Testbench for the infix-to-postfix converter: stream stimulus, shunting-yard predictor, scoreboard.
module tb_infix_to_postfix_converter;
  import i2p_pkg::*;

  // Predicts postfix items from accepted expression characters and checks the results
  class postfix_scoreboard;
    typedef struct {
      ch_t  c;
      logic last;
      logic done;
      logic ovf;
    } post_item_t;

    ch_t        ops[STACK_DEPTH_DEF];
    int         op_cnt;
    ch_t        hold[3];
    int         hold_n;
    bit         sp_pend;
    bit         none_yet;
    bit         ovf_seen;
    ch_t        wbuf[4];
    string      wtext[NUM_WORDS];
    ch_t        wcode[NUM_WORDS];
    post_item_t step_q[$];
    post_item_t pending[$];
    int         errors;
    int         n_in;
    int         n_res;
    int         n_ovf;
    int         n_exprs;

    function new();
      wtext = '{"sin", "sqrt", "cos", "tan", "log", "ln", "./", ".*", ".+", ".-", ".^"};
      wcode = '{"s", "q", "c", "t", "l", "n", "d", "m", "a", "u", "p"};
      op_cnt = 0; hold_n = 0; sp_pend = 0; none_yet = 1; ovf_seen = 0;
      errors = 0; n_in = 0; n_res = 0; n_ovf = 0; n_exprs = 0;
    endfunction

    function void put_raw(ch_t c);
      post_item_t r;
      if (step_q.size() < MAX_RESULTS) begin
        r.c = c; r.last = 0; r.done = 0; r.ovf = ovf_seen;
        step_q.push_back(r);
      end
    endfunction

    function void emit(ch_t c);
      if (sp_pend && !none_yet) put_raw(CH_SPACE);
      put_raw(c);
      sp_pend = 0;
      none_yet = 0;
    endfunction

    function void separate();
      if (!none_yet) sp_pend = 1;
    endfunction

    function void push(ch_t c);
      if (op_cnt < STACK_DEPTH_DEF) begin
        ops[op_cnt] = c;
        op_cnt++;
      end else begin
        ovf_seen = 1;
      end
    endfunction

    function ch_t pop_top();
      if (op_cnt == 0) return 8'h00;
      op_cnt--;
      return ops[op_cnt];
    endfunction

    function int rank(ch_t c);
      case (c)
        "+", "-": return 1;
        "a", "u": return 2;
        "*", "/", "m", "d": return 3;
        "^", "p", "s", "q", "c", "t", "l", "n": return 4;
        default: return 0;
      endcase
    endfunction

    function bit leaves_first(ch_t top, ch_t cur);
      if (rank(top) == rank(cur)) return top != CH_CARET;
      return rank(top) > rank(cur);
    endfunction

    function bit binop_char(ch_t c);
      return c == "+" || c == "-" || c == "*" || c == "/" || c == "^" ||
             c == "a" || c == "p" || c == "u" || c == "m" || c == "d";
    endfunction

    function bit operand_char(ch_t c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
             (c >= "A" && c <= "Z") || c == ".";
    endfunction

    function void stack_operator(ch_t code);
      while (op_cnt > 0 && ops[op_cnt-1] != CH_LPAREN && leaves_first(ops[op_cnt-1], code)) begin
        separate();
        emit(pop_top());
      end
      push(code);
    endfunction

    function void plain(ch_t x);
      if (binop_char(x)) begin
        stack_operator(x);
        separate();
      end else if (operand_char(x)) begin
        emit(x);
      end else if (x == CH_LPAREN) begin
        push(x);
        separate();
      end else if (x == CH_RPAREN) begin
        while (op_cnt > 0 && ops[op_cnt-1] != CH_LPAREN) begin
          separate();
          emit(pop_top());
          separate();
        end
        if (op_cnt > 0) op_cnt--;
        separate();
      end else begin
        separate();
      end
    endfunction

    // fold words out of the character window, buffering an incomplete prefix
    function void scan_window(int len, bit fin);
      ch_t x;
      int  adv;
      int  full;
      bit  pre;
      bit  same;
      int  wl;
      while (len > 0) begin
        x = wbuf[0];
        adv = 1;
        if (x == "s" || x == "c" || x == "t" || x == "l" || x == ".") begin
          full = -1;
          pre = 0;
          for (int i = 0; i < NUM_WORDS; i++) begin
            wl = wtext[i].len();
            same = 1;
            for (int k = 0; k < ((len < wl) ? len : wl); k++)
              if (wbuf[k] != wtext[i][k]) same = 0;
            if (same && len >= wl) full = i;
            else if (same) pre = 1;
          end
          if (full >= 0) begin
            adv = wtext[full].len();
            stack_operator(wcode[full]);
            if (!operand_char(wbuf[adv-1])) separate();
          end else if (pre && !fin && len <= 3) begin
            for (int k = 0; k < len; k++) hold[k] = wbuf[k];
            hold_n = len;
            return;
          end else begin
            emit(x);
          end
        end else begin
          plain(x);
        end
        for (int k = 0; k + adv < len; k++) wbuf[k] = wbuf[k+adv];
        len -= adv;
      end
    endfunction

    // accepted input item: predict its results
    function void note_input(ch_t c, bit e);
      int n;
      n = hold_n;
      for (int k = 0; k < n; k++) wbuf[k] = hold[k];
      wbuf[n] = c;
      hold_n = 0;
      step_q.delete();
      scan_window(n + 1, e);
      if (e) begin
        while (op_cnt > 0) begin
          separate();
          emit(pop_top());
        end
        op_cnt = 0; hold_n = 0; sp_pend = 0; none_yet = 1; ovf_seen = 0;
        n_exprs++;
      end
      if (step_q.size() > 0) begin
        step_q[step_q.size()-1].last = 1;
        if (e) step_q[step_q.size()-1].done = 1;
      end
      foreach (step_q[i]) pending.push_back(step_q[i]);
      n_in++;
    endfunction

    // accepted result item: compare with the oldest prediction
    function void check_result(ch_t c, logic last, logic [1:0] user);
      post_item_t p;
      n_res++;
      if (user[1]) n_ovf++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected item: char %h last %b user %b", $time, c, last, user);
        errors++;
        return;
      end
      p = pending.pop_front();
      if (p.c !== c) begin
        $display("%0t: char mismatch: expected %h actual %h", $time, p.c, c);
        errors++;
      end
      if (p.last !== last) begin
        $display("%0t: last mismatch: expected %b actual %b", $time, p.last, last);
        errors++;
      end
      if (p.done !== user[0]) begin
        $display("%0t: done mismatch: expected %b actual %b", $time, p.done, user[0]);
        errors++;
      end
      if (p.ovf !== user[1]) begin
        $display("%0t: overflow mismatch: expected %b actual %b", $time, p.ovf, user[1]);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] in_char
  logic       in_tlast;   // in_end
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] out_char
  logic       out_tlast;  // run_last
  logic [1:0] out_tuser;  // [0] expr_done, [1] overflow

  postfix_scoreboard sb;
  bit                hold_off_go;
  ch_t               expr_q[$];

  infix_to_postfix_converter dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  always #2 clk = ~clk;

  // mostly short gaps, a few long ones, often none
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one item and wait for it to be taken
  task automatic send_item(ch_t c, bit e);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= e;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(c, e);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], i == s.len() - 1);
  endtask

  task automatic send_queue();
    for (int i = 0; i < expr_q.size(); i++) send_item(expr_q[i], i == expr_q.size() - 1);
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) expr_q.push_back(s[i]);
  endfunction

  function automatic void add_operand();
    string pool;
    pool = "0123456789xyzbeghkABZ.";
    if ($urandom_range(0, 4) == 0) add_text("sin");
    else if ($urandom_range(0, 5) == 0) add_text("sqrt");
    expr_q.push_back(pool[$urandom_range(0, pool.len() - 1)]);
    if ($urandom_range(0, 3) == 0) expr_q.push_back(pool[$urandom_range(0, 9)]);
  endfunction

  function automatic void add_operator();
    string ops [14];
    ops = '{"+", "-", "*", "/", "^", "a", "p", "u", "m", "d", ".*", "./", ".^", ".+"};
    add_text(ops[$urandom_range(0, 13)]);
    if ($urandom_range(0, 2) == 0) expr_q.push_back(CH_SPACE);
  endfunction

  // mostly well-formed expressions with random content, some broken or noisy
  function automatic void build_expr();
    int terms;
    int depth;
    int r;
    string prefixes [7];
    prefixes = '{"s", "sq", "sqr", "co", "ta", "l", "."};
    expr_q.delete();
    r = $urandom_range(0, 99);
    if (r < 8) begin
      repeat ($urandom_range(1, 6)) expr_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (r < 11) begin
      repeat ($urandom_range(15, 19)) expr_q.push_back(CH_LPAREN);
      add_operand();
      return;
    end
    if ($urandom_range(0, 3) == 0) expr_q.push_back(CH_SPACE);
    terms = $urandom_range(1, 5);
    depth = 0;
    for (int i = 0; i < terms; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        expr_q.push_back(CH_LPAREN);
        depth++;
      end
      add_operand();
      if (depth > 0 && $urandom_range(0, 2) == 0) begin
        expr_q.push_back(CH_RPAREN);
        depth--;
      end
      if ($urandom_range(0, 9) == 0) expr_q.push_back(8'($urandom_range(0, 255)));
      if (i < terms - 1) add_operator();
    end
    if (r < 20) expr_q.push_back(CH_RPAREN);
    else if (r < 28) add_text(prefixes[$urandom_range(0, 6)]);
    else while (depth > 0 && $urandom_range(0, 1) == 0) begin
      expr_q.push_back(CH_RPAREN);
      depth--;
    end
    if ($urandom_range(0, 4) == 0) expr_q.push_back(CH_SPACE);
  endfunction

  // receiver: random stalls plus one long hold-off while the sender keeps going
  initial begin
    int stall;
    bit held;
    stall = 0;
    held = 0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_go && !held) begin
        held = 1;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 19) == 0) begin
        stall = gap_len();
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast, out_tuser);
  end

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    in_tlast = 1'b0;
    hold_off_go = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: failed word, right associativity, empty output, stack overflow
    send_text("sx+b^c^d");
    send_text("  ");
    send_text("(((((((((((((((((z");

    // random expressions
    while (sb.n_in < 290) begin
      if (sb.n_in > 80) hold_off_go = 1;
      build_expr();
      send_queue();
    end
    in_tvalid <= 1'b0;

    while (sb.pending.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Sent %0d characters in %0d expressions; checked %0d results, %0d flagged overflow.",
             sb.n_in, sb.n_exprs, sb.n_res, sb.n_ovf);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/i2p_pkg.sv
rtl/i2p_front.sv
rtl/i2p_back.sv
rtl/infix_to_postfix_converter.sv
test/tb_infix_to_postfix_converter.sv
